// ===== rtl/bpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpdc_pkg
// Shared types and constants of the button press duration classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bpdc_pkg;

    // Buttons that the sample and the result word carry
    localparam int NUM_VISIBLE = 4;

    localparam int LIMIT_W = 16;
    localparam int CLASS_W = 3;
    localparam int ADDR_W  = 4;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 24;

    // Register map, index taken from paddr[3:2]
    localparam logic [1:0] REG_SHORT  = 2'd0;
    localparam logic [1:0] REG_LONG   = 2'd1;
    localparam logic [1:0] REG_LONGER = 2'd2;
    localparam logic [1:0] REG_RESET  = 2'd3;

    localparam logic [LIMIT_W-1:0] SHORT_RST  = 16'd250;
    localparam logic [LIMIT_W-1:0] LONG_RST   = 16'd1500;
    localparam logic [LIMIT_W-1:0] LONGER_RST = 16'd5000;
    localparam logic [LIMIT_W-1:0] RESET_RST  = 16'd15000;

    // Hold classes
    localparam logic [CLASS_W-1:0] CLS_NONE   = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_SHORT  = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_MEDIUM = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_LONG   = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_XLONG  = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_RESET  = 3'd5;

    typedef struct packed {
        logic [LIMIT_W-1:0] short_ms;
        logic [LIMIT_W-1:0] long_ms;
        logic [LIMIT_W-1:0] longer_ms;
        logic [LIMIT_W-1:0] reset_ms;
    } limits_t;

    typedef struct packed {
        logic               released;
        logic [CLASS_W-1:0] cls;
        logic               pressed;
        logic               long_hold;
    } lane_result_t;

endpackage

`default_nettype wire

// ===== rtl/button_press_duration_classifier.sv =====
// ----------------------------------------------------------------------------
// button_press_duration_classifier
// Classifies how long each of four active-low buttons is held.
// ----------------------------------------------------------------------------
// One sample word is taken per clock, and its result word appears on the
// master side in the cycle after it is accepted; the only stall comes from
// m_tready held low while a result waits in the output register. Each button
// has its own lane that forms the hold duration with one subtract and checks
// it against the four limit registers in parallel, which sets the cycle path.
// Every sample yields exactly one result word. Limits are written over the
// APB port (short, long, longer, reset limit at 0x0, 0x4, 0x8, 0xC) and take
// effect from the next sample. No initialization pass is needed after reset.
`default_nettype none

module button_press_duration_classifier #(
    parameter int NUM_BUTTONS = 4,
    parameter int TIME_BITS   = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bpdc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // sample stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [3:0] levels, [35:4] now_ms, [39:36] zero
    input  wire logic [bpdc_pkg::IN_W-1:0]     s_tdata,
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [3:0] release_mask, [6:4] class_b0, [9:7] class_b1, [12:10] class_b2,
    // [15:13] class_b3, [19:16] pressed_mask, [23:20] long_hold_mask
    output logic [bpdc_pkg::OUT_W-1:0]         m_tdata
);

    // Buttons past the sampled ones always read released and never report
    localparam int LANES = (NUM_BUTTONS < bpdc_pkg::NUM_VISIBLE) ?
                           NUM_BUTTONS : bpdc_pkg::NUM_VISIBLE;

    bpdc_pkg::limits_t                                 limits_reg;
    bpdc_pkg::lane_result_t [bpdc_pkg::NUM_VISIBLE-1:0] lanes;
    logic [3:0]                                        levels;
    logic [31:0]                                       now_ms;
    logic [TIME_BITS-1:0]                              now_t;
    logic                                              accept;
    logic                                              cfg_write;

    assign levels = s_tdata[3:0];
    assign now_ms = s_tdata[35:4];
    assign now_t  = TIME_BITS'(now_ms);
    assign accept = s_tvalid && s_tready;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.short_ms  <= bpdc_pkg::SHORT_RST;
            limits_reg.long_ms   <= bpdc_pkg::LONG_RST;
            limits_reg.longer_ms <= bpdc_pkg::LONGER_RST;
            limits_reg.reset_ms  <= bpdc_pkg::RESET_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                bpdc_pkg::REG_SHORT:  limits_reg.short_ms  <= pwdata[15:0];
                bpdc_pkg::REG_LONG:   limits_reg.long_ms   <= pwdata[15:0];
                bpdc_pkg::REG_LONGER: limits_reg.longer_ms <= pwdata[15:0];
                bpdc_pkg::REG_RESET:  limits_reg.reset_ms  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            bpdc_pkg::REG_SHORT:  prdata = 32'(limits_reg.short_ms);
            bpdc_pkg::REG_LONG:   prdata = 32'(limits_reg.long_ms);
            bpdc_pkg::REG_LONGER: prdata = 32'(limits_reg.longer_ms);
            bpdc_pkg::REG_RESET:  prdata = 32'(limits_reg.reset_ms);
            default:              prdata = '0;
        endcase
    end

    // Per-button lanes
    for (genvar b = 0; b < bpdc_pkg::NUM_VISIBLE; b++)
    begin : g_lane
        if (b < LANES)
        begin : g_on
            bpdc_lane #(
                .TIME_BITS (TIME_BITS)
            ) u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (accept),
                .level   (levels[b]),
                .now_t   (now_t),
                .limits  (limits_reg),
                .result  (lanes[b])
            );
        end
        else
        begin : g_off
            assign lanes[b] = '0;
        end
    end

    bpdc_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .lanes    (lanes),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/bpdc_lane.sv =====
// ----------------------------------------------------------------------------
// bpdc_lane
// Per-button edge tracking and hold duration classification.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdc_lane #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire logic                   level,
    input  wire logic [TIME_BITS-1:0]   now_t,
    input  wire bpdc_pkg::limits_t      limits,
    output bpdc_pkg::lane_result_t      result
);

    logic                            prev_reg;
    logic [TIME_BITS-1:0]            start_reg;
    logic [TIME_BITS-1:0]            start_next;
    logic [bpdc_pkg::CLASS_W-1:0]    class_reg;
    logic [bpdc_pkg::CLASS_W-1:0]    class_next;
    logic [bpdc_pkg::CLASS_W-1:0]    class_dur;
    logic [TIME_BITS-1:0]            dur;

    assign dur = now_t - start_reg;

    always_comb
    begin
        if (dur < TIME_BITS'(limits.short_ms))
            class_dur = bpdc_pkg::CLS_SHORT;
        else if (dur < TIME_BITS'(limits.long_ms))
            class_dur = bpdc_pkg::CLS_MEDIUM;
        else if (dur < TIME_BITS'(limits.longer_ms))
            class_dur = bpdc_pkg::CLS_LONG;
        else if (dur > TIME_BITS'(limits.reset_ms))
            class_dur = bpdc_pkg::CLS_RESET;
        else
            class_dur = bpdc_pkg::CLS_XLONG;
    end

    always_comb
    begin
        start_next      = start_reg;
        class_next      = class_reg;
        result.released = 1'b0;
        result.cls      = bpdc_pkg::CLS_NONE;
        if (prev_reg && !level)
        begin
            start_next = now_t;
            class_next = bpdc_pkg::CLS_NONE;
        end
        else if (!prev_reg && !level)
        begin
            class_next = class_dur;
        end
        else if (!prev_reg && level)
        begin
            // report only a release that carried a class
            result.released = (class_reg != bpdc_pkg::CLS_NONE);
            result.cls      = class_reg;
            class_next      = bpdc_pkg::CLS_NONE;
        end
        result.pressed   = !level;
        result.long_hold = !level && (class_next > bpdc_pkg::CLS_MEDIUM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            start_reg <= '0;
            class_reg <= bpdc_pkg::CLS_NONE;
        end
        else if (advance)
        begin
            prev_reg  <= level;
            start_reg <= start_next;
            class_reg <= class_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bpdc_merge.sv =====
// ----------------------------------------------------------------------------
// bpdc_merge
// Combines the lane results into one result word and holds it for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdc_merge (
    input  wire logic                                                clk,
    input  wire logic                                                rst_n,
    input  wire logic                                                s_valid,
    output logic                                                     s_ready,
    input  wire bpdc_pkg::lane_result_t [bpdc_pkg::NUM_VISIBLE-1:0]  lanes,
    output logic                                                     m_tvalid,
    input  wire logic                                                m_tready,
    output logic [bpdc_pkg::OUT_W-1:0]                               m_tdata
);

    logic                          valid_reg;
    logic [bpdc_pkg::OUT_W-1:0]    data_reg;
    logic [bpdc_pkg::OUT_W-1:0]    data_next;
    logic                          load;

    always_comb
    begin
        data_next = '0;
        for (int b = 0; b < bpdc_pkg::NUM_VISIBLE; b++)
        begin
            data_next[b]             = lanes[b].released;
            data_next[4 + 3*b +: 3]  = lanes[b].cls;
            data_next[16 + b]        = lanes[b].pressed;
            data_next[20 + b]        = lanes[b].long_hold;
        end
    end

    // take a new word whenever the held one leaves or there is none
    assign s_ready  = !valid_reg || m_tready;
    assign load     = s_valid && s_ready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s_ready)
            valid_reg <= s_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire
